// ===== rtl/cqps_pkg.sv =====
`timescale 1ns / 1ps

package cqps_pkg;

  // action codes
  localparam logic [2:0] ACT_PUSH   = 3'd0;
  localparam logic [2:0] ACT_POP    = 3'd1;
  localparam logic [2:0] ACT_REMOVE = 3'd2;
  localparam logic [2:0] ACT_FIND   = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_EMPTY    = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data;
    logic [4:0] position;
    logic [4:0] occupancy;
    logic       last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cqps_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic single_op;
    logic is_find;
    logic scan_done;
    logic hit;
    logic pend_valid;
    logic out_free;
  } cqps_status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } ctrl_state_e;

  function automatic out_item_t make_result(input logic [1:0] status,
                                            input logic [7:0] data,
                                            input logic [4:0] position,
                                            input logic [4:0] occupancy,
                                            input logic       last);
    out_item_t r;
    r.status    = status;
    r.data      = data;
    r.position  = position;
    r.occupancy = occupancy;
    r.last      = last;
    return r;
  endfunction

endpackage

// ===== rtl/cqps_ctrl.sv =====
`timescale 1ns / 1ps

module cqps_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_known_i,
  output logic                   in_ready_o,
  input  cqps_pkg::cqps_status_t status_i,
  output cqps_pkg::cqps_cmd_t    cmd_o
);
  import cqps_pkg::*;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          // drop undefined actions without a result
          if (in_known_i) state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status_i.single_op) begin
          cmd_o.finish = status_i.out_free;
        end else if (!status_i.scan_done) begin
          // hold the scan while an earlier hit cannot be handed on
          cmd_o.step = !(status_i.is_find && status_i.hit &&
                         status_i.pend_valid && !status_i.out_free);
        end else begin
          cmd_o.finish = status_i.out_free;
        end
        if (cmd_o.finish) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/cqps_datapath.sv =====
`timescale 1ns / 1ps

module cqps_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cqps_pkg::in_item_t     in_item_i,
  input  cqps_pkg::cqps_cmd_t    cmd_i,
  output cqps_pkg::cqps_status_t status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output cqps_pkg::out_item_t    out_item_o
);
  import cqps_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data_q;
  logic [IW-1:0] rd_addr;
  logic          we;
  logic [IW-1:0] waddr;
  logic [7:0]    wdata;

  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] wr_q, wr_d;
  logic [CW-1:0] pend_q, pend_d;
  logic          pend_valid_q, pend_valid_d;
  logic [2:0]    op_q, op_d;
  logic [7:0]    key_q, key_d;
  logic          out_valid_q;
  out_item_t     out_q;
  logic          emit;
  out_item_t     emit_item;
  logic          out_free;
  logic          hit;

  // circular index of the entry at a given offset from the head
  function automatic logic [IW-1:0] slot_at(input logic [IW-1:0] head,
                                            input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) sum = sum - (CW+1)'(DEPTH);
    return sum[IW-1:0];
  endfunction

  assign out_free = !out_valid_q || out_ready_i;
  assign hit      = (rd_data_q == key_q);

  assign status_o.single_op  = (op_q == ACT_PUSH) || (op_q == ACT_POP) ||
                               (op_q == ACT_CLEAR);
  assign status_o.is_find    = (op_q == ACT_FIND);
  assign status_o.scan_done  = (idx_q == count_q);
  assign status_o.hit        = hit;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = out_free;

  // read address is the entry examined in the next cycle
  always_comb begin
    if (cmd_i.load) begin
      rd_addr = head_q;
    end else if (cmd_i.step) begin
      rd_addr = slot_at(head_q, idx_q + 1'b1);
    end else begin
      rd_addr = slot_at(head_q, idx_q);
    end
  end

  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    idx_d        = idx_q;
    wr_d         = wr_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    op_d         = op_q;
    key_d        = key_q;
    we           = 1'b0;
    waddr        = slot_at(head_q, wr_q);
    wdata        = rd_data_q;
    emit         = 1'b0;
    emit_item    = make_result(STAT_OK, 8'h00, 5'd0, 5'(count_q), 1'b1);

    if (cmd_i.load) begin
      op_d         = in_item_i.action;
      key_d        = in_item_i.value;
      idx_d        = '0;
      wr_d         = '0;
      pend_valid_d = 1'b0;
    end

    if (cmd_i.step) begin
      idx_d = idx_q + 1'b1;
      if (op_q == ACT_REMOVE) begin
        // compact kept entries towards the head
        if (!hit) begin
          we   = 1'b1;
          wr_d = wr_q + 1'b1;
        end
      end else if (hit) begin
        if (pend_valid_q) begin
          emit      = 1'b1;
          emit_item = make_result(STAT_OK, 8'h00, 5'(pend_q), 5'(count_q), 1'b0);
        end
        pend_d       = idx_q + 1'b1;
        pend_valid_d = 1'b1;
      end
    end

    if (cmd_i.finish) begin
      emit = 1'b1;
      unique case (op_q)
        ACT_PUSH: begin
          if (count_q == FULL_CNT) begin
            emit_item = make_result(STAT_FULL, 8'h00, 5'd0, 5'(count_q), 1'b1);
          end else begin
            we        = 1'b1;
            waddr     = slot_at(head_q, count_q);
            wdata     = key_q;
            count_d   = count_q + 1'b1;
            emit_item = make_result(STAT_OK, 8'h00, 5'd0, 5'(count_d), 1'b1);
          end
        end
        ACT_POP: begin
          if (count_q == '0) begin
            emit_item = make_result(STAT_EMPTY, 8'h00, 5'd0, 5'(count_q), 1'b1);
          end else begin
            head_d    = slot_at(head_q, CW'(1));
            count_d   = count_q - 1'b1;
            emit_item = make_result(STAT_OK, rd_data_q, 5'd0, 5'(count_d), 1'b1);
          end
        end
        ACT_REMOVE: begin
          count_d   = wr_q;
          emit_item = make_result((wr_q != count_q) ? STAT_OK : STAT_NOTFOUND,
                                  8'h00, 5'd0, 5'(wr_q), 1'b1);
        end
        ACT_FIND: begin
          if (pend_valid_q) begin
            emit_item = make_result(STAT_OK, 8'h00, 5'(pend_q), 5'(count_q), 1'b1);
          end else begin
            emit_item = make_result(STAT_NOTFOUND, 8'h00, 5'd0, 5'(count_q), 1'b1);
          end
        end
        ACT_CLEAR: begin
          if (count_q == '0) begin
            emit_item = make_result(STAT_EMPTY, 8'h00, 5'd0, 5'd0, 1'b1);
          end else begin
            count_d   = '0;
            emit_item = make_result(STAT_OK, 8'h00, 5'd0, 5'd0, 1'b1);
          end
        end
        default: emit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      wr_q         <= '0;
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
      op_q         <= ACT_PUSH;
      out_valid_q  <= 1'b0;
    end else begin
      head_q       <= head_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      wr_q         <= wr_d;
      pend_q       <= pend_d;
      pend_valid_q <= pend_valid_d;
      op_q         <= op_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (emit) out_q <= emit_item;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/char_queue_with_purge_and_search.sv =====
`timescale 1ns / 1ps

// Bounded byte queue of DEPTH entries with push, pop, remove-all-matching, find and
// clear, one action per input transaction and one or more result transactions out
// per defined action; undefined action codes give no result. Remove and find walk
// the stored entries through the single read port of the element store, one entry
// per cycle unless an earlier find hit still waits for the output register. Any
// action takes longer while the output is stalled, since each result waits for the
// output register to free. A new transaction is taken once the previous one has
// finished, even while its last result still waits in the output register. The
// element store needs no clearing after reset; the queue is empty at once.
module char_queue_with_purge_and_search #(
  parameter int DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cqps_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cqps_pkg::out_item_t out_item_o
);
  import cqps_pkg::*;

  cqps_cmd_t    cmd;
  cqps_status_t status;
  logic         in_known;

  assign in_known = (in_item_i.action <= ACT_CLEAR);

  cqps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_known_i (in_known),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cqps_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== rtl/cqps_checker.sv =====
`timescale 1ns / 1ps

module cqps_checker #(
  parameter int DEPTH = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input cqps_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input cqps_pkg::out_item_t out_item_o
);
  import cqps_pkg::*;

  logic in_seen;
  assign in_seen = in_valid_i && in_ready_o && (in_item_i.value == in_item_i.value);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(out_item_o.occupancy) <= DEPTH))
    else $error("occupancy beyond depth");

  // failures are single, final results without a position
  a_fail_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != STAT_OK) |->
      out_item_o.last && (out_item_o.position == 5'd0) && (out_item_o.data == 8'h00))
    else $error("failure result malformed");

  // a find hit never carries data, a pop never carries a position
  a_pos_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.position != 5'd0) |-> (out_item_o.data == 8'h00))
    else $error("position and data both set");

  // no transaction is taken while a non-final result is stalled at the output
  a_no_accept_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last && !out_ready_i |-> !in_seen)
    else $error("input taken during a multi-result find");

endmodule

bind char_queue_with_purge_and_search cqps_checker #(.DEPTH(DEPTH)) u_cqps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import cqps_pkg::*;

  localparam int QDEPTH = 16;
  localparam int DIRECTED_ITEMS = 28;
  localparam int RANDOM_ITEMS = 190;
  localparam int PAUSE_AT = 110;
  localparam int HOLD_AT = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int CALM_FROM = 150;
  localparam int CALM_TO = 190;
  localparam int IDLE_PERCENT = 34;
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  typedef struct {
    in_item_t item;
    bit       drain;
  } pending_action_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  char_queue_with_purge_and_search #(
    .DEPTH(QDEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  pending_action_t queued_actions[$];
  out_item_t       awaited_results[$];
  int              results_predicted = 0;
  int              results_checked = 0;
  int              items_taken = 0;
  int              error_count = 0;
  int              planned = 0;
  bit              pause_planned = 1'b0;
  int              hold_left = 0;
  bit              hold_done = 1'b0;
  int              quiet_cycles = 0;
  logic            calm;

  assign calm = (items_taken >= CALM_FROM) && (items_taken < CALM_TO);

  // shadow of the queue contents
  logic [7:0] image_slot[QDEPTH];
  int         image_head = 0;
  int         image_count = 0;

  task automatic log_result(input logic [1:0] status, input logic [7:0] data,
                            input int position, input bit last);
    out_item_t r;
    r.status    = status;
    r.data      = data;
    r.position  = 5'(position);
    r.occupancy = 5'(image_count);
    r.last      = last;
    awaited_results.push_back(r);
    results_predicted++;
  endtask

  task automatic apply_action(input in_item_t it);
    logic [7:0] kept[QDEPTH];
    logic [7:0] popped;
    int         n;
    int         hits;
    int         k;
    n = 0;
    hits = 0;
    k = 0;
    case (it.action)
      ACT_PUSH: begin
        if (image_count >= QDEPTH) begin
          log_result(STAT_FULL, '0, 0, 1'b1);
        end else begin
          image_slot[(image_head + image_count) % QDEPTH] = it.value;
          image_count++;
          log_result(STAT_OK, '0, 0, 1'b1);
        end
      end
      ACT_POP: begin
        if (image_count == 0) begin
          log_result(STAT_EMPTY, '0, 0, 1'b1);
        end else begin
          popped = image_slot[image_head];
          image_head = (image_head + 1) % QDEPTH;
          image_count--;
          log_result(STAT_OK, popped, 0, 1'b1);
        end
      end
      ACT_REMOVE: begin
        for (int i = 0; i < image_count; i++) begin
          if (image_slot[(image_head + i) % QDEPTH] == it.value) begin
            hits++;
          end else begin
            kept[n] = image_slot[(image_head + i) % QDEPTH];
            n++;
          end
        end
        // compact the survivors towards the head, order kept
        for (int i = 0; i < n; i++) image_slot[(image_head + i) % QDEPTH] = kept[i];
        image_count = n;
        log_result((hits > 0) ? STAT_OK : STAT_NOTFOUND, '0, 0, 1'b1);
      end
      ACT_FIND: begin
        for (int i = 0; i < image_count; i++)
          if (image_slot[(image_head + i) % QDEPTH] == it.value) hits++;
        if (hits == 0) begin
          log_result(STAT_NOTFOUND, '0, 0, 1'b1);
        end else begin
          for (int i = 0; i < image_count; i++) begin
            if (image_slot[(image_head + i) % QDEPTH] == it.value) begin
              k++;
              log_result(STAT_OK, '0, i + 1, k == hits);
            end
          end
        end
      end
      ACT_CLEAR: begin
        if (image_count == 0) begin
          log_result(STAT_EMPTY, '0, 0, 1'b1);
        end else begin
          image_count = 0;
          log_result(STAT_OK, '0, 0, 1'b1);
        end
      end
      default: ;  // spare action codes produce nothing
    endcase
  endtask

  // sender: take over the accepted transaction, then offer the next one
  always @(posedge clk_i or negedge rst_ni) begin
    pending_action_t upcoming;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        apply_action(in_item_i);
        items_taken <= items_taken + 1;
      end
      if (in_valid_i && !in_ready_o) begin
        // hold until accepted
      end else if (queued_actions.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (queued_actions[0].drain && results_predicted != results_checked) begin
        in_valid_i <= 1'b0;
      end else if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
        in_valid_i <= 1'b0;
      end else begin
        upcoming = queued_actions.pop_front();
        in_valid_i <= 1'b1;
        in_item_i  <= upcoming.item;
      end
    end
  end

  // receiver: check each result transaction against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_checked <= results_checked + 1;
        if (awaited_results.size() == 0) begin
          $error("unexpected result: status %0d data %0d position %0d occupancy %0d last %0d",
                 out_item_o.status, out_item_o.data, out_item_o.position,
                 out_item_o.occupancy, out_item_o.last);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_item_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item_o.status);
            error_count++;
          end
          if (out_item_o.data !== want.data) begin
            $error("data: expected %0d, got %0d", want.data, out_item_o.data);
            error_count++;
          end
          if (out_item_o.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_item_o.position);
            error_count++;
          end
          if (out_item_o.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, out_item_o.occupancy);
            error_count++;
          end
          if (out_item_o.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_item_o.last);
            error_count++;
          end
        end
      end
      // one long back-pressure spell so the queue backs up into the input
      if (!hold_done && items_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (calm) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic offer(input logic [2:0] action, input logic [7:0] value);
    pending_action_t p;
    p.item.action = action;
    p.item.value  = value;
    p.drain       = 1'b0;
    if (action <= ACT_CLEAR) begin
      planned++;
      // wait for the queue to go quiet once, mid-run
      if (!pause_planned && planned >= PAUSE_AT) begin
        pause_planned = 1'b1;
        p.drain = 1'b1;
      end
    end
    queued_actions.push_back(p);
  endtask

  // mostly a few recurring keys so finds and removes hit
  function automatic logic [7:0] pick_value();
    logic [7:0] keys[4] = '{8'h00, 8'h3C, 8'hA5, 8'hFF};
    if ($urandom_range(3) != 0) return keys[$urandom_range(3)];
    return 8'($urandom);
  endfunction

  function automatic logic [2:0] pick_action();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return ACT_PUSH;
    if (roll < 58) return ACT_POP;
    if (roll < 70) return ACT_REMOVE;
    if (roll < 90) return ACT_FIND;
    if (roll < 96) return ACT_CLEAR;
    return 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
  endfunction

  initial begin
    logic [7:0] fill_pattern[QDEPTH] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F,
                                         8'hFE, 8'hFF, 8'h10, 8'h20, 8'h40, 8'h08, 8'h04,
                                         8'h02, 8'hFF};
    logic [7:0] key;
    int         mode;
    int         n;

    // empty-queue cases and spare codes
    offer(ACT_POP, 8'h00);
    offer(ACT_CLEAR, 8'h00);
    offer(ACT_REMOVE, 8'h42);
    offer(ACT_FIND, 8'h42);
    offer(ACT_SPARE_LO, 8'hFF);
    offer(ACT_SPARE_HI, 8'h00);
    // fill up, overflow, search and purge
    foreach (fill_pattern[i]) offer(ACT_PUSH, fill_pattern[i]);
    offer(ACT_PUSH, 8'h33);
    offer(ACT_FIND, 8'hFF);
    offer(ACT_FIND, 8'h99);
    offer(ACT_REMOVE, 8'hFF);
    offer(ACT_REMOVE, 8'hFF);
    offer(ACT_POP, 8'h00);
    offer(ACT_CLEAR, 8'h00);

    while (planned < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      mode = $urandom_range(9);
      if (mode == 0) begin
        // a queue full of one key: a find returns every position
        key = pick_value();
        offer(ACT_CLEAR, 8'($urandom));
        n = $urandom_range(QDEPTH + 2, QDEPTH);
        repeat (n) offer(ACT_PUSH, key);
        offer(ACT_FIND, key);
        offer($urandom_range(1) ? ACT_REMOVE : ACT_POP, key);
      end else if (mode < 4) begin
        n = $urandom_range(20, 6);
        repeat (n) offer(ACT_PUSH, pick_value());
        offer(ACT_FIND, pick_value());
      end else if (mode < 6) begin
        n = $urandom_range(10, 3);
        repeat (n) offer(($urandom_range(9) < 7) ? ACT_POP : ACT_REMOVE, pick_value());
      end else begin
        n = $urandom_range(15, 5);
        repeat (n) offer(pick_action(), pick_value());
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (queued_actions.size() != 0 || in_valid_i);
    do @(negedge clk_i); while (results_predicted != results_checked);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cqps_pkg.sv
rtl/cqps_ctrl.sv
rtl/cqps_datapath.sv
rtl/char_queue_with_purge_and_search.sv
rtl/cqps_checker.sv
tb/testbench.sv
